// ----- rtl/rbsi_pkg.sv -----
// ---------------------------------------------------------------------------
// rbsi_pkg
// shared constants for the ray / box slab intersection block
// ---------------------------------------------------------------------------
`default_nettype none

package rbsi_pkg;

  // default coordinate format, signed q16.16
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // configuration register map
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_MIN_X = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_MIN_Y = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_MIN_Z = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_MAX_X = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_MAX_Y = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_MAX_Z = CFG_INDEX_W'(5);

  // distance magnitude is split in two halves of this width for the point multiply
  localparam int SPLIT_W = 32;
  // offset magnitudes at or above 2**MAG_CAP_W always saturate a point
  localparam int MAG_CAP_W = 40;

endpackage

`default_nettype wire

// ----- rtl/ray_box_slab_intersect.sv -----
// ---------------------------------------------------------------------------
// ray_box_slab_intersect
// ray against axis-aligned box, slab method, signed fixed point
// ---------------------------------------------------------------------------
// usage
//   cfg channel: one beat writes one box corner coordinate, cfg_index picks
//   the register (min x/y/z, max x/y/z); cfg_ready is always high; write only
//   while no ray is in flight
//   in channel: one beat is one ray (origin and direction per axis)
//   out channel: one beat per ray, in order: overlap flag, in-front flag,
//   entry/exit distances and entry/exit points
// throughput: one ray per cycle, fully pipelined
// latency: COORD_WIDTH + FRAC_BITS + 10 cycles from in beat to out beat
//   (58 at q16.16), set by the bit-per-stage slab distance dividers
// reset: box registers clear to zero, all pipeline valids and the input
//   skid clear; payload registers are not reset
// stall: when out_ready is low with a beat waiting, the whole pipeline holds;
//   in_ready comes from a register and one more ray is caught in the input
//   skid, so nothing is lost or repeated
// valid for COORD_WIDTH up to 32 and FRAC_BITS up to 29
// ---------------------------------------------------------------------------
`default_nettype none

module ray_box_slab_intersect #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbsi_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [COORD_WIDTH-1:0]              cfg_data,
  // ray in
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       origin_x,
  input  logic signed [COORD_WIDTH-1:0]       origin_y,
  input  logic signed [COORD_WIDTH-1:0]       origin_z,
  input  logic signed [COORD_WIDTH-1:0]       dir_x,
  input  logic signed [COORD_WIDTH-1:0]       dir_y,
  input  logic signed [COORD_WIDTH-1:0]       dir_z,
  // result out
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                slabs_overlap,
  output logic                                hit_in_front,
  output logic signed [COORD_WIDTH-1:0]       t_entry,
  output logic signed [COORD_WIDTH-1:0]       t_exit,
  output logic signed [COORD_WIDTH-1:0]       entry_x,
  output logic signed [COORD_WIDTH-1:0]       entry_y,
  output logic signed [COORD_WIDTH-1:0]       entry_z,
  output logic signed [COORD_WIDTH-1:0]       exit_x,
  output logic signed [COORD_WIDTH-1:0]       exit_y,
  output logic signed [COORD_WIDTH-1:0]       exit_z
);

  import rbsi_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int NW    = W + 1 + F;          // shifted numerator / quotient width
  localparam int TW    = NW + 1;             // signed slab distance width
  localparam int MT_W  = 2 * SPLIT_W;        // padded distance magnitude
  localparam int PW    = SPLIT_W + W;        // partial product width
  localparam int CW    = PW + SPLIT_W;       // recombined product width
  localparam int MC_W  = MAG_CAP_W + 1;      // capped offset magnitude
  localparam int SUM_W = ((W > MC_W) ? W : MC_W) + 2;

  localparam logic signed [W-1:0]     O_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]     O_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [TW-1:0]    T_MAX = TW'(O_MAX);
  localparam logic signed [TW-1:0]    T_MIN = TW'(O_MIN);
  localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'(O_MAX);
  localparam logic signed [SUM_W-1:0] S_MIN = SUM_W'(O_MIN);
  localparam logic [CW-1:0]           CAP_C = CW'(1) << MAG_CAP_W;

  typedef struct packed {
    logic [2:0][W-1:0] o;
    logic [2:0][W-1:0] d;
    logic [2:0]        sn;       // near distance is negative
    logic [2:0]        sf;       // far distance is negative
    logic [2:0]        dz;       // direction component is zero
    logic              outmiss;  // parallel axis with origin outside slab
  } sb_t;

  function automatic logic signed [W-1:0] sat_t(input logic signed [TW-1:0] v);
    if (v > T_MAX) begin
      sat_t = O_MAX;
    end else if (v < T_MIN) begin
      sat_t = O_MIN;
    end else begin
      sat_t = v[W-1:0];
    end
  endfunction

  function automatic logic signed [W-1:0] sat_s(input logic signed [SUM_W-1:0] v);
    if (v > S_MAX) begin
      sat_s = O_MAX;
    end else if (v < S_MIN) begin
      sat_s = O_MIN;
    end else begin
      sat_s = v[W-1:0];
    end
  endfunction

  function automatic logic [NW-1:0] mag_t(input logic signed [TW-1:0] v);
    mag_t = v[TW-1] ? NW'(-v) : NW'(v);
  endfunction

  // ---------------------------------------------------------------------
  // box registers
  // ---------------------------------------------------------------------
  logic signed [W-1:0] box_min [3];
  logic signed [W-1:0] box_max [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_min[a] <= '0;
        box_max[a] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BOX_MIN_X: box_min[0] <= cfg_data;
        REG_BOX_MIN_Y: box_min[1] <= cfg_data;
        REG_BOX_MIN_Z: box_min[2] <= cfg_data;
        REG_BOX_MAX_X: box_max[0] <= cfg_data;
        REG_BOX_MAX_Y: box_max[1] <= cfg_data;
        REG_BOX_MAX_Z: box_max[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // global advance and input skid
  // ---------------------------------------------------------------------
  logic                en;
  logic                in_fire;
  logic                skid_full;
  logic signed [W-1:0] skid_o [3];
  logic signed [W-1:0] skid_d [3];
  logic signed [W-1:0] in_o   [3];
  logic signed [W-1:0] in_d   [3];
  logic                fr_valid;
  logic signed [W-1:0] fr_o   [3];
  logic signed [W-1:0] fr_d   [3];

  // the pipeline moves whenever the output register is free or being drained
  assign en       = !out_valid || out_ready;
  assign in_ready = !skid_full;
  assign in_fire  = in_valid && in_ready;

  assign in_o[0] = origin_x;
  assign in_o[1] = origin_y;
  assign in_o[2] = origin_z;
  assign in_d[0] = dir_x;
  assign in_d[1] = dir_y;
  assign in_d[2] = dir_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (en) begin
      skid_full <= 1'b0;
    end else if (in_fire) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_fire) begin
      skid_o <= in_o;
      skid_d <= in_d;
    end
  end

  // front of the pipe takes the parked beat first
  assign fr_valid = skid_full || in_fire;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      fr_o[a] = skid_full ? skid_o[a] : in_o[a];
      fr_d[a] = skid_full ? skid_d[a] : in_d[a];
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: plane minus origin, near plane picked by direction sign
  // ---------------------------------------------------------------------
  logic                s1_valid;
  logic signed [W-1:0] s1_o  [3];
  logic signed [W-1:0] s1_d  [3];
  logic signed [W:0]   s1_dn [3];
  logic signed [W:0]   s1_df [3];
  logic [2:0]          s1_out;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s1_o[a] <= fr_o[a];
        s1_d[a] <= fr_d[a];
        if (fr_d[a][W-1]) begin
          s1_dn[a] <= (W+1)'(box_max[a]) - (W+1)'(fr_o[a]);
          s1_df[a] <= (W+1)'(box_min[a]) - (W+1)'(fr_o[a]);
        end else begin
          s1_dn[a] <= (W+1)'(box_min[a]) - (W+1)'(fr_o[a]);
          s1_df[a] <= (W+1)'(box_max[a]) - (W+1)'(fr_o[a]);
        end
        s1_out[a] <= (fr_d[a] == '0) &&
                     ((fr_o[a] < box_min[a]) || (fr_o[a] > box_max[a]));
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: magnitudes and quotient signs
  // ---------------------------------------------------------------------
  logic             s2_valid;
  logic [W:0]       s2_nn [3];
  logic [W:0]       s2_nf [3];
  logic [W-1:0]     s2_dm [3];
  sb_t              s2_sb;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s2_nn[a]    <= s1_dn[a][W] ? (W+1)'(-s1_dn[a]) : (W+1)'(s1_dn[a]);
        s2_nf[a]    <= s1_df[a][W] ? (W+1)'(-s1_df[a]) : (W+1)'(s1_df[a]);
        s2_dm[a]    <= s1_d[a][W-1] ? W'(-s1_d[a]) : W'(s1_d[a]);
        s2_sb.o[a]  <= s1_o[a];
        s2_sb.d[a]  <= s1_d[a];
        s2_sb.sn[a] <= s1_dn[a][W] ^ s1_d[a][W-1];
        s2_sb.sf[a] <= s1_df[a][W] ^ s1_d[a][W-1];
        s2_sb.dz[a] <= (s1_d[a] == '0);
      end
      s2_sb.outmiss <= |s1_out;
    end
  end

  // ---------------------------------------------------------------------
  // slab distance dividers, six lanes, sideband travels alongside
  // ---------------------------------------------------------------------
  logic [NW-1:0] div_num_n [3];
  logic [NW-1:0] div_num_f [3];
  logic [NW-1:0] qn [3];
  logic [NW-1:0] qf [3];

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_axis
      assign div_num_n[g] = NW'(s2_nn[g]) << F;
      assign div_num_f[g] = NW'(s2_nf[g]) << F;

      rbsi_div_pipe #(
        .NUM_W (NW),
        .DEN_W (W)
      ) u_div_near (
        .clk  (clk),
        .en   (en),
        .num  (div_num_n[g]),
        .den  (s2_dm[g]),
        .quot (qn[g])
      );

      rbsi_div_pipe #(
        .NUM_W (NW),
        .DEN_W (W)
      ) u_div_far (
        .clk  (clk),
        .en   (en),
        .num  (div_num_f[g]),
        .den  (s2_dm[g]),
        .quot (qf[g])
      );
    end
  endgenerate

  logic [NW-1:0] dv_valid;
  sb_t           dv_sb [NW];

  always_ff @(posedge clk) begin
    if (en) begin
      dv_sb[0] <= s2_sb;
      for (int k = 1; k < NW; k++) begin
        dv_sb[k] <= dv_sb[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: signed distances
  // ---------------------------------------------------------------------
  logic                 s3_valid;
  logic signed [TW-1:0] s3_lo [3];
  logic signed [TW-1:0] s3_hi [3];
  logic signed [W-1:0]  s3_o  [3];
  logic signed [W-1:0]  s3_d  [3];
  logic [2:0]           s3_dz;
  logic                 s3_outmiss;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s3_lo[a] <= dv_sb[NW-1].sn[a] ? -$signed({1'b0, qn[a]}) : $signed({1'b0, qn[a]});
        s3_hi[a] <= dv_sb[NW-1].sf[a] ? -$signed({1'b0, qf[a]}) : $signed({1'b0, qf[a]});
        s3_o[a]  <= dv_sb[NW-1].o[a];
        s3_d[a]  <= dv_sb[NW-1].d[a];
      end
      s3_dz      <= dv_sb[NW-1].dz;
      s3_outmiss <= dv_sb[NW-1].outmiss;
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: intersect x and y intervals, parallel axes drop out
  // ---------------------------------------------------------------------
  logic                 s4_valid;
  logic signed [TW-1:0] s4_lo01;
  logic signed [TW-1:0] s4_hi01;
  logic                 s4_v01;
  logic signed [TW-1:0] s4_lo2;
  logic signed [TW-1:0] s4_hi2;
  logic                 s4_v2;
  logic signed [W-1:0]  s4_o [3];
  logic signed [W-1:0]  s4_d [3];
  logic                 s4_outmiss;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_lo01 <= (!s3_dz[0] && (s3_dz[1] || s3_lo[0] > s3_lo[1])) ? s3_lo[0] : s3_lo[1];
      s4_hi01 <= (!s3_dz[0] && (s3_dz[1] || s3_hi[0] < s3_hi[1])) ? s3_hi[0] : s3_hi[1];
      s4_v01     <= !s3_dz[0] || !s3_dz[1];
      s4_lo2     <= s3_lo[2];
      s4_hi2     <= s3_hi[2];
      s4_v2      <= !s3_dz[2];
      s4_o       <= s3_o;
      s4_d       <= s3_d;
      s4_outmiss <= s3_outmiss;
    end
  end

  // ---------------------------------------------------------------------
  // stage 5: fold in z
  // ---------------------------------------------------------------------
  logic                 s5_valid;
  logic signed [TW-1:0] s5_tlo;
  logic signed [TW-1:0] s5_thi;
  logic                 s5_bounded;
  logic signed [W-1:0]  s5_o [3];
  logic signed [W-1:0]  s5_d [3];
  logic                 s5_outmiss;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_tlo     <= (s4_v01 && (!s4_v2 || s4_lo01 > s4_lo2)) ? s4_lo01 : s4_lo2;
      s5_thi     <= (s4_v01 && (!s4_v2 || s4_hi01 < s4_hi2)) ? s4_hi01 : s4_hi2;
      s5_bounded <= s4_v01 || s4_v2;
      s5_o       <= s4_o;
      s5_d       <= s4_d;
      s5_outmiss <= s4_outmiss;
    end
  end

  // ---------------------------------------------------------------------
  // stage 6: miss test, reported distances, multiplier operands
  // ---------------------------------------------------------------------
  logic                s6_valid;
  logic                s6_miss;
  logic                s6_front;
  logic signed [W-1:0] s6_te;
  logic signed [W-1:0] s6_tx;
  logic [MT_W-1:0]     s6_mte;
  logic [MT_W-1:0]     s6_mtx;
  logic [W-1:0]        s6_md   [3];
  logic [2:0]          s6_neg_e;
  logic [2:0]          s6_neg_x;
  logic signed [W-1:0] s6_o    [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s6_miss  <= s5_outmiss || (s5_bounded && s5_tlo > s5_thi);
      s6_front <= s5_bounded && (s5_tlo > 0);
      // a ray with no bounded axis spans the whole line
      s6_te    <= s5_bounded ? sat_t(s5_tlo) : O_MIN;
      s6_tx    <= s5_bounded ? sat_t(s5_thi) : O_MAX;
      s6_mte   <= MT_W'(mag_t(s5_tlo));
      s6_mtx   <= MT_W'(mag_t(s5_thi));
      for (int a = 0; a < 3; a++) begin
        s6_md[a]    <= s5_d[a][W-1] ? W'(-s5_d[a]) : W'(s5_d[a]);
        s6_neg_e[a] <= s5_tlo[TW-1] ^ s5_d[a][W-1];
        s6_neg_x[a] <= s5_thi[TW-1] ^ s5_d[a][W-1];
      end
      s6_o <= s5_o;
    end
  end

  // ---------------------------------------------------------------------
  // stage 7: partial products of distance times direction
  // ---------------------------------------------------------------------
  logic                s7_valid;
  logic [PW-1:0]       s7_phe [3];
  logic [PW-1:0]       s7_ple [3];
  logic [PW-1:0]       s7_phx [3];
  logic [PW-1:0]       s7_plx [3];
  logic                s7_miss;
  logic                s7_front;
  logic signed [W-1:0] s7_te;
  logic signed [W-1:0] s7_tx;
  logic [2:0]          s7_neg_e;
  logic [2:0]          s7_neg_x;
  logic signed [W-1:0] s7_o [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s7_phe[a] <= PW'(s6_mte[MT_W-1:SPLIT_W]) * PW'(s6_md[a]);
        s7_ple[a] <= PW'(s6_mte[SPLIT_W-1:0])    * PW'(s6_md[a]);
        s7_phx[a] <= PW'(s6_mtx[MT_W-1:SPLIT_W]) * PW'(s6_md[a]);
        s7_plx[a] <= PW'(s6_mtx[SPLIT_W-1:0])    * PW'(s6_md[a]);
      end
      s7_miss  <= s6_miss;
      s7_front <= s6_front;
      s7_te    <= s6_te;
      s7_tx    <= s6_tx;
      s7_neg_e <= s6_neg_e;
      s7_neg_x <= s6_neg_x;
      s7_o     <= s6_o;
    end
  end

  // ---------------------------------------------------------------------
  // stage 8: recombine, drop fraction, cap the offset magnitude
  // ---------------------------------------------------------------------
  logic                s8_valid;
  logic [MC_W-1:0]     s8_mce [3];
  logic [MC_W-1:0]     s8_mcx [3];
  logic [CW-1:0]       s8_me  [3];
  logic [CW-1:0]       s8_mx  [3];
  logic                s8_miss;
  logic                s8_front;
  logic signed [W-1:0] s8_te;
  logic signed [W-1:0] s8_tx;
  logic [2:0]          s8_neg_e;
  logic [2:0]          s8_neg_x;
  logic signed [W-1:0] s8_o [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      s8_me[a] = ((CW'(s7_phe[a]) << SPLIT_W) + CW'(s7_ple[a])) >> F;
      s8_mx[a] = ((CW'(s7_phx[a]) << SPLIT_W) + CW'(s7_plx[a])) >> F;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        s8_mce[a] <= (s8_me[a] >= CAP_C) ? MC_W'(CAP_C) : s8_me[a][MC_W-1:0];
        s8_mcx[a] <= (s8_mx[a] >= CAP_C) ? MC_W'(CAP_C) : s8_mx[a][MC_W-1:0];
      end
      s8_miss  <= s7_miss;
      s8_front <= s7_front;
      s8_te    <= s7_te;
      s8_tx    <= s7_tx;
      s8_neg_e <= s7_neg_e;
      s8_neg_x <= s7_neg_x;
      s8_o     <= s7_o;
    end
  end

  // ---------------------------------------------------------------------
  // output register: origin plus offset, saturate, zero on a miss
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_e [3];
  logic signed [SUM_W-1:0] sum_x [3];
  logic signed [W-1:0]     pt_e  [3];
  logic signed [W-1:0]     pt_x  [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum_e[a] = s8_neg_e[a] ? SUM_W'(s8_o[a]) - $signed(SUM_W'(s8_mce[a]))
                             : SUM_W'(s8_o[a]) + $signed(SUM_W'(s8_mce[a]));
      sum_x[a] = s8_neg_x[a] ? SUM_W'(s8_o[a]) - $signed(SUM_W'(s8_mcx[a]))
                             : SUM_W'(s8_o[a]) + $signed(SUM_W'(s8_mcx[a]));
      pt_e[a]  = sat_s(sum_e[a]);
      pt_x[a]  = sat_s(sum_x[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slabs_overlap <= !s8_miss;
      hit_in_front  <= !s8_miss && s8_front;
      t_entry       <= s8_miss ? '0 : s8_te;
      t_exit        <= s8_miss ? '0 : s8_tx;
      entry_x       <= s8_miss ? '0 : pt_e[0];
      entry_y       <= s8_miss ? '0 : pt_e[1];
      entry_z       <= s8_miss ? '0 : pt_e[2];
      exit_x        <= s8_miss ? '0 : pt_x[0];
      exit_y        <= s8_miss ? '0 : pt_x[1];
      exit_z        <= s8_miss ? '0 : pt_x[2];
    end
  end

  // ---------------------------------------------------------------------
  // valid bits
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      dv_valid  <= '0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      s8_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= fr_valid;
      s2_valid  <= s1_valid;
      dv_valid  <= {dv_valid[NW-2:0], s2_valid};
      s3_valid  <= dv_valid[NW-1];
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      s6_valid  <= s5_valid;
      s7_valid  <= s6_valid;
      s8_valid  <= s7_valid;
      out_valid <= s8_valid;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rbsi_div_pipe.sv -----
// ---------------------------------------------------------------------------
// rbsi_div_pipe
// pipelined unsigned restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
`default_nettype none

module rbsi_div_pipe #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot
);

  // numerator bits shift out at the top while quotient bits shift in below
  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W-1];
  logic [DEN_W-1:0] den_q [NUM_W-1];

  genvar k;
  generate
    for (k = 0; k < NUM_W; k++) begin : g_step
      logic [DEN_W-1:0] rem_in;
      logic [DEN_W-1:0] den_in;
      logic [NUM_W-1:0] nq_in;
      logic [DEN_W:0]   trial;
      logic             take;
      logic [DEN_W-1:0] rem_new;

      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign den_in = den;
        assign nq_in  = num;
      end else begin : g_next
        assign rem_in = rem_q[k-1];
        assign den_in = den_q[k-1];
        assign nq_in  = nq_q[k-1];
      end

      assign trial   = {rem_in, nq_in[NUM_W-1]};
      assign take    = trial >= {1'b0, den_in};
      assign rem_new = take ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];

      always_ff @(posedge clk) begin
        if (en) begin
          nq_q[k] <= {nq_in[NUM_W-2:0], take};
        end
      end

      if (k < NUM_W - 1) begin : g_carry
        always_ff @(posedge clk) begin
          if (en) begin
            rem_q[k] <= rem_new;
            den_q[k] <= den_in;
          end
        end
      end
    end
  endgenerate

  assign quot = nq_q[NUM_W-1];

endmodule

`default_nettype wire

// ----- rtl/rbsi_checker.sv -----
// ---------------------------------------------------------------------------
// rbsi_checker
// port-level checks on the ray / box slab intersection block
// ---------------------------------------------------------------------------
`default_nettype none

module rbsi_checker #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             slabs_overlap,
  input logic                             hit_in_front,
  input logic signed [COORD_WIDTH-1:0]    t_entry,
  input logic signed [COORD_WIDTH-1:0]    t_exit,
  input logic signed [COORD_WIDTH-1:0]    entry_x,
  input logic signed [COORD_WIDTH-1:0]    entry_y,
  input logic signed [COORD_WIDTH-1:0]    entry_z,
  input logic signed [COORD_WIDTH-1:0]    exit_x,
  input logic signed [COORD_WIDTH-1:0]    exit_y,
  input logic signed [COORD_WIDTH-1:0]    exit_z
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(t_entry) && $stable(t_exit)
      && $stable(slabs_overlap))
    else $error("result beat changed while stalled");

  // in front only when the slabs overlap
  a_front_needs_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit_in_front |-> slabs_overlap)
    else $error("in-front flag without overlap");

  // a miss reports zero everywhere
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !slabs_overlap |-> t_entry == '0 && t_exit == '0 && entry_x == '0
      && entry_y == '0 && entry_z == '0 && exit_x == '0 && exit_y == '0 && exit_z == '0)
    else $error("miss with non-zero payload");

  // overlapping intervals are ordered
  a_interval_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && slabs_overlap |-> t_entry <= t_exit)
    else $error("entry distance beyond exit distance");

endmodule

bind ray_box_slab_intersect rbsi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbsi_checker (.*);

`default_nettype wire

// ----- test/tb_ray_box_slab_intersect.sv -----
// ---------------------------------------------------------------------------
// tb_ray_box_slab_intersect
// self-checking bench for the ray / box slab intersection pipeline: rays are
// driven over valid/ready with random idling on both sides, each result beat
// is checked against a slab-method predictor held in a scoreboard class
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ray_box_slab_intersect;
  import rbsi_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int LATENCY = CW + FB + 10;
  localparam longint SMAX = 64'sd2147483647;
  localparam longint SMIN = -64'sd2147483648;

  // one predicted result beat
  typedef struct {
    bit overlap;
    bit front;
    logic [CW-1:0] te, tx;
    logic [CW-1:0] en[3];
    logic [CW-1:0] ex[3];
  } hit_t;

  // scoreboard: box copy, slab predictor and queue of pending hits
  class ray_scoreboard;
    longint bmin[3], bmax[3];
    hit_t pending[$];
    int errors;
    int checked;

    function new();
      foreach (bmin[a]) begin
        bmin[a] = 0;
        bmax[a] = 0;
      end
      errors = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CW-1:0] v);
      longint s;
      s = longint'($signed(v));
      case (idx)
        REG_BOX_MIN_X: bmin[0] = s;
        REG_BOX_MIN_Y: bmin[1] = s;
        REG_BOX_MIN_Z: bmin[2] = s;
        REG_BOX_MAX_X: bmax[0] = s;
        REG_BOX_MAX_Y: bmax[1] = s;
        REG_BOX_MAX_Z: bmax[2] = s;
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
    endfunction

    // plane distance, quotient toward zero, kept wide
    function longint slab_dist(longint p, longint o, longint d);
      longint num;
      longint unsigned q;
      num = p - o;
      q = ((num < 0 ? -num : num) << FB) / (d < 0 ? -d : d);
      return ((num < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // origin plus t*d scaled down, saturated
    function longint walk(longint o, longint t, longint d);
      longint unsigned mt, md, hi, lo, q, m;
      bit neg;
      if (d == 0 || t == 0) return sat(o);
      mt = t < 0 ? -t : t;
      md = d < 0 ? -d : d;
      neg = (t < 0) != (d < 0);
      hi = mt >> 32;
      lo = mt & 64'hFFFF_FFFF;
      q = hi * md;
      if (q >= (64'd1 << (8 + FB))) return neg ? SMIN : SMAX;
      m = (q << (32 - FB)) + ((lo * md) >> FB);
      if (m >= (64'd1 << MAG_CAP_W)) return neg ? SMIN : SMAX;
      return sat(o + (neg ? -longint'(m) : longint'(m)));
    endfunction

    function void note_ray(logic [CW-1:0] org[3], logic [CW-1:0] dir[3]);
      longint o[3], d[3], t_lo, t_hi, lo, hi;
      bit bounded, miss;
      hit_t h;
      t_lo = 0;
      t_hi = 0;
      bounded = 0;
      miss = 0;
      for (int a = 0; a < 3; a++) begin
        o[a] = longint'($signed(org[a]));
        d[a] = longint'($signed(dir[a]));
      end
      for (int a = 0; a < 3; a++) begin
        if (d[a] == 0) begin
          if (o[a] < bmin[a] || o[a] > bmax[a]) miss = 1;
        end else begin
          // near plane chosen by direction sign
          if (d[a] > 0) begin
            lo = slab_dist(bmin[a], o[a], d[a]);
            hi = slab_dist(bmax[a], o[a], d[a]);
          end else begin
            lo = slab_dist(bmax[a], o[a], d[a]);
            hi = slab_dist(bmin[a], o[a], d[a]);
          end
          if (!bounded) begin
            t_lo = lo;
            t_hi = hi;
            bounded = 1;
          end else begin
            if (lo > t_lo) t_lo = lo;
            if (hi < t_hi) t_hi = hi;
          end
        end
      end
      if (bounded && t_lo > t_hi) miss = 1;
      h.overlap = 0;
      h.front = 0;
      h.te = '0;
      h.tx = '0;
      for (int a = 0; a < 3; a++) begin
        h.en[a] = '0;
        h.ex[a] = '0;
      end
      if (!miss) begin
        h.overlap = 1;
        h.front = bounded && t_lo > 0;
        h.te = CW'(bounded ? sat(t_lo) : SMIN);
        h.tx = CW'(bounded ? sat(t_hi) : SMAX);
        for (int a = 0; a < 3; a++) begin
          h.en[a] = CW'(bounded ? walk(o[a], t_lo, d[a]) : o[a]);
          h.ex[a] = CW'(bounded ? walk(o[a], t_hi, d[a]) : o[a]);
        end
      end
      pending.push_back(h);
    endfunction

    function void cmp(string name, logic [CW-1:0] e, logic [CW-1:0] g);
      if (e !== g) begin
        $error("%s: expected %0d actual %0d", name, $signed(e), $signed(g));
        errors++;
      end
    endfunction

    function void check_hit(hit_t got);
      hit_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      cmp("slabs_overlap", CW'(e.overlap), CW'(got.overlap));
      cmp("hit_in_front", CW'(e.front), CW'(got.front));
      cmp("t_entry", e.te, got.te);
      cmp("t_exit", e.tx, got.tx);
      cmp("entry_x", e.en[0], got.en[0]);
      cmp("entry_y", e.en[1], got.en[1]);
      cmp("entry_z", e.en[2], got.en[2]);
      cmp("exit_x", e.ex[0], got.ex[0]);
      cmp("exit_y", e.ex[1], got.ex[1]);
      cmp("exit_z", e.ex[2], got.ex[2]);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [CW-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [CW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic out_valid;
  logic out_ready = 0;
  logic slabs_overlap, hit_in_front;
  logic signed [CW-1:0] t_entry, t_exit;
  logic signed [CW-1:0] entry_x, entry_y, entry_z, exit_x, exit_y, exit_z;

  ray_box_slab_intersect uut (.*);

  always #5 clk = ~clk;

  ray_scoreboard sb = new();

  // idling percentages, changed per phase
  int send_idle = 33;
  int recv_idle = 85;
  // long receiver hold-off, counted in the receiver process
  int hold_cycles = 0;
  int rays_sent = 0;
  int box_settings = 0;

  // ---- receive side: ready decided at the falling edge, beat taken at rising
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    hit_t g;
    if (!rst && out_valid && out_ready) begin
      g.overlap = slabs_overlap;
      g.front = hit_in_front;
      g.te = t_entry;
      g.tx = t_exit;
      g.en[0] = entry_x;
      g.en[1] = entry_y;
      g.en[2] = entry_z;
      g.ex[0] = exit_x;
      g.ex[1] = exit_y;
      g.ex[2] = exit_z;
      sb.check_hit(g);
    end
  end

  // ---- send side
  // valid stays up after a beat so the next ray can follow back to back;
  // callers that stop sending drop it
  task automatic send_ray(logic [CW-1:0] o[3], logic [CW-1:0] d[3]);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    origin_x <= o[0];
    origin_y <= o[1];
    origin_z <= o[2];
    dir_x <= d[0];
    dir_y <= d[1];
    dir_z <= d[2];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_ray(o, d);
    rays_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CW-1:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // wait for every pending beat, then let the pipeline drain fully
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_box(logic [CW-1:0] lo[3], logic [CW-1:0] hi[3]);
    drain();
    write_reg(REG_BOX_MIN_X, lo[0]);
    write_reg(REG_BOX_MIN_Y, lo[1]);
    write_reg(REG_BOX_MIN_Z, lo[2]);
    write_reg(REG_BOX_MAX_X, hi[0]);
    write_reg(REG_BOX_MAX_Y, hi[1]);
    write_reg(REG_BOX_MAX_Z, hi[2]);
    box_settings++;
  endtask

  // mixed-magnitude coordinate: mostly small, some full range, some extremes
  function automatic logic [CW-1:0] rand_coord();
    int r;
    r = $urandom_range(99);
    if (r < 55) return CW'($signed($urandom_range(20 << FB)) - (10 << FB));
    if (r < 70) return CW'($signed($urandom_range(512)) - 256);
    if (r < 80) return '0;
    if (r < 85) return 32'h7FFF_FFFF;
    if (r < 90) return 32'h8000_0000;
    return CW'($urandom);
  endfunction

  function automatic logic [CW-1:0] rand_dir();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 25) return CW'($urandom_range(1)) ? 32'h0000_0001 : 32'hFFFF_FFFF;
    if (r < 75) return CW'($signed($urandom_range(4 << FB)) - (2 << FB));
    return CW'($urandom);
  endfunction

  task automatic random_rays(int count);
    logic [CW-1:0] o[3], d[3];
    repeat (count) begin
      for (int a = 0; a < 3; a++) begin
        o[a] = rand_coord();
        d[a] = rand_dir();
      end
      send_ray(o, d);
    end
  endtask

  task automatic random_box();
    logic [CW-1:0] lo[3], hi[3];
    logic [CW-1:0] t;
    for (int a = 0; a < 3; a++) begin
      lo[a] = rand_coord();
      hi[a] = rand_coord();
      // keep most boxes well formed, some inverted
      if ($signed(lo[a]) > $signed(hi[a]) && $urandom_range(9) != 0) begin
        t = lo[a];
        lo[a] = hi[a];
        hi[a] = t;
      end
    end
    set_box(lo, hi);
  endtask

  initial begin
    logic [CW-1:0] o[3], d[3], lo[3], hi[3];
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: unit box from -1 to +1
    lo = '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000};
    hi = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
    set_box(lo, hi);
    // plain hit along x from the left
    o = '{32'hFFFB_0000, 0, 0}; d = '{32'h0001_0000, 0, 0}; send_ray(o, d);
    // negative direction, near plane is max
    o = '{32'h0005_0000, 0, 0}; d = '{32'hFFFF_0000, 0, 0}; send_ray(o, d);
    // zero direction with origin outside: miss
    o = '{32'hFFFB_0000, 32'h0005_0000, 0}; d = '{32'h0001_0000, 0, 0}; send_ray(o, d);
    // all direction zero, origin inside: unbounded
    o = '{0, 0, 0}; d = '{0, 0, 0}; send_ray(o, d);
    // all zero, origin on the boundary
    o = '{32'h0001_0000, 32'hFFFF_0000, 0}; d = '{0, 0, 0}; send_ray(o, d);
    // origin inside, hit behind
    o = '{0, 0, 0}; d = '{32'h0001_0000, 32'h0000_8000, 32'hFFFF_4000}; send_ray(o, d);
    // diagonal ray crossing the box in x and y
    o = '{32'hFFFE_0000, 32'hFFFE_0000, 0}; d = '{32'h0001_0000, 32'h0001_0000, 0};
    send_ray(o, d);
    // disjoint slabs: miss
    o = '{32'hFFFD_0000, 32'h0003_0000, 0}; d = '{32'h0001_0000, 32'h0001_0000, 0};
    send_ray(o, d);
    // field extremes
    o = '{32'h7FFF_FFFF, 32'h8000_0000, 0}; d = '{32'h8000_0000, 32'h7FFF_FFFF, 1};
    send_ray(o, d);
    o = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; d = '{1, 1, 1}; send_ray(o, d);
    o = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    d = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}; send_ray(o, d);
    o = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    d = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}; send_ray(o, d);

    // inverted box on x: always a miss there
    lo = '{32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000};
    hi = '{32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000};
    set_box(lo, hi);
    o = '{0, 0, 0}; d = '{0, 32'h0001_0000, 0}; send_ray(o, d);
    o = '{32'hFFFB_0000, 0, 0}; d = '{32'h0001_0000, 0, 0}; send_ray(o, d);

    // extreme box: the full range on every axis
    lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    hi = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    set_box(lo, hi);
    o = '{0, 0, 0}; d = '{1, 32'hFFFF_FFFF, 32'h0000_0100}; send_ray(o, d);
    o = '{32'h8000_0000, 32'h7FFF_FFFF, 0}; d = '{32'h0001_0000, 0, 0}; send_ray(o, d);
    o = '{32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F};
    d = '{32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_0003}; send_ray(o, d);

    // random phase one: sender idles a third, receiver mostly stalls
    send_idle = 33;
    recv_idle = 85;
    for (int p = 0; p < 4; p++) begin
      random_box();
      random_rays(130);
    end

    // long receiver hold-off while rays keep coming, so the input stalls
    in_valid <= 0;
    @(negedge clk);
    hold_cycles <= 3 * LATENCY;
    send_idle = 0;
    random_rays(80);

    // sender pauses until every pending beat is out
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);

    // phase two: roles swapped
    send_idle = 85;
    recv_idle = 33;
    for (int p = 0; p < 4; p++) begin
      random_box();
      random_rays(130);
    end

    // phase three: no idling at all
    send_idle = 0;
    recv_idle = 0;
    for (int p = 0; p < 4; p++) begin
      random_box();
      random_rays(140);
    end

    drain();
    $display("%0d rays over %0d box settings, %0d result beats checked",
             rays_sent, box_settings, sb.checked);
    $display("directed edge rays, inverted and full-range boxes, stalls on both sides");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_ray_box_slab_intersect: PASS");
    end else begin
      $display("tb_ray_box_slab_intersect: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("tb_ray_box_slab_intersect: FAIL");
    $finish;
  end

endmodule
